@@ src/fla_pkg.sv @@
`default_nettype none

package fla_pkg;

    // Pool depth used when the top level is not overridden
    localparam int POOL_SIZE_DEF = 64;

    // Fixed field widths
    localparam int REQ_W    = 2;
    localparam int IDENT_W  = 6;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 7;

    // Request codes
    typedef enum logic [REQ_W-1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_RSVD  = 2'd3
    } req_e_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EXHAUSTED = 2'd1,
        ST_BAD_FREE  = 2'd2
    } status_t;

    // Controller states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // One result word
    typedef struct packed {
        logic [LIVE_W-1:0]  live_count;
        logic               is_allocated;
        status_t            status;
        logic [IDENT_W-1:0] granted_ident;
    } result_t;

endpackage

`default_nettype wire

@@ src/free_list_id_allocator_unit.sv @@
`default_nettype none

// Channel  | Dir | Word bits (lowest first)
// ---------+-----+------------------------------------------------------------
// s_axis   | in  | req_type[1:0], ident[7:2]
// m_axis   | out | granted_ident[5:0], status[7:6], is_allocated[8],
//          |     | live_count[15:9]
//
// Each request first reads the link memory entry at the free-list head
// (allocate) or at the identifier (free, query), then updates it and loads
// the result register; the registered read of the link memory keeps these
// steps apart. Reset clears the head, fill mark and live count at once;
// no clearing pass runs. A new request is taken while a result waits in the
// output register; the update cycle holds while that register stays full.

module free_list_id_allocator_unit #(
    parameter int POOL_SIZE = fla_pkg::POOL_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // req_type[1:0], ident[7:2]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata    // granted_ident, status, is_allocated, live_count
);

    localparam int ADDR_W = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
    localparam int LINK_W = $clog2(POOL_SIZE + 1);

    logic              res_valid;
    logic              res_room;
    fla_pkg::result_t  res;
    fla_pkg::result_t  out_reg;
    logic              out_valid_reg;

    logic [ADDR_W-1:0] ram_rd_addr;
    logic [LINK_W:0]   ram_rd_data;
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [LINK_W:0]   ram_wr_data;

    assign res_room = !out_valid_reg || m_tready;

    fla_ctrl #(
        .POOL_SIZE (POOL_SIZE),
        .ADDR_W    (ADDR_W),
        .LINK_W    (LINK_W)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .req_valid   (s_tvalid),
        .req_ready   (s_tready),
        .req_type    (s_tdata[1:0]),
        .req_ident   (s_tdata[7:2]),
        .res_room    (res_room),
        .res_valid   (res_valid),
        .res         (res),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data)
    );

    fla_link_ram #(
        .DEPTH  (POOL_SIZE),
        .ADDR_W (ADDR_W),
        .DATA_W (LINK_W + 1)
    ) u_ram (
        .aclk    (aclk),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data)
    );

    // Hold the result word until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_room) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_room && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

`default_nettype wire

@@ src/fla_link_ram.sv @@
`default_nettype none

module fla_link_ram #(
    parameter int DEPTH  = fla_pkg::POOL_SIZE_DEF,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 8
) (
    input  wire logic              aclk,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write one entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read
    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ src/fla_ctrl.sv @@
`default_nettype none

module fla_ctrl #(
    parameter int POOL_SIZE = fla_pkg::POOL_SIZE_DEF,
    parameter int ADDR_W    = 6,
    parameter int LINK_W    = 7
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // request side
    input  wire logic                        req_valid,
    output logic                             req_ready,
    input  wire logic [fla_pkg::REQ_W-1:0]   req_type,
    input  wire logic [fla_pkg::IDENT_W-1:0] req_ident,
    // result side
    input  wire logic                        res_room,
    output logic                             res_valid,
    output fla_pkg::result_t                 res,
    // link memory
    output logic      [ADDR_W-1:0]           ram_rd_addr,
    input  wire logic [LINK_W:0]             ram_rd_data,
    output logic                             ram_wr_en,
    output logic      [ADDR_W-1:0]           ram_wr_addr,
    output logic      [LINK_W:0]             ram_wr_data
);

    localparam int CMP_W = (LINK_W > fla_pkg::IDENT_W) ? LINK_W : fla_pkg::IDENT_W;

    fla_pkg::state_t   state_reg, state_next;
    fla_pkg::req_e_t   req_reg, req_next;
    logic [LINK_W-1:0] head_reg, head_next;
    logic [LINK_W-1:0] fill_reg, fill_next;
    logic [LINK_W-1:0] used_reg, used_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              known_reg, known_next;

    logic              accept;
    logic [ADDR_W-1:0] new_addr;
    logic              id_known;
    logic              alloc_flag;
    logic [LINK_W-1:0] link;

    assign accept = req_valid && req_ready;

    // Entry address of the incoming request and whether it was ever written
    always_comb begin
        id_known = (CMP_W'(req_ident) < CMP_W'(POOL_SIZE))
                && (CMP_W'(req_ident) < CMP_W'(fill_reg));
        if (fla_pkg::req_e_t'(req_type) == fla_pkg::REQ_ALLOC) begin
            new_addr = head_reg[ADDR_W-1:0];
        end else begin
            new_addr = ADDR_W'(req_ident);
        end
    end

    // Hold the read address for the whole operation
    assign ram_rd_addr = accept ? new_addr : addr_reg;

    // Entries at or above the fill mark were never written; they read as free, linked to the next entry
    assign alloc_flag = known_reg && ram_rd_data[LINK_W];
    assign link       = known_reg ? ram_rd_data[LINK_W-1:0] : head_reg + 1'b1;

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= fla_pkg::S_IDLE;
            head_reg  <= '0;
            fill_reg  <= '0;
            used_reg  <= '0;
        end else begin
            state_reg <= state_next;
            head_reg  <= head_next;
            fill_reg  <= fill_next;
            used_reg  <= used_next;
        end
    end

    // Capture the request
    always_ff @(posedge aclk) begin
        req_reg   <= req_next;
        addr_reg  <= addr_next;
        known_reg <= known_next;
    end

    // Next state, memory write and result
    always_comb begin
        state_next  = state_reg;
        req_next    = req_reg;
        addr_next   = addr_reg;
        known_next  = known_reg;
        head_next   = head_reg;
        fill_next   = fill_reg;
        used_next   = used_reg;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = addr_reg;
        ram_wr_data = {1'b1, link};
        res.granted_ident = '0;
        res.status        = fla_pkg::ST_OK;
        res.is_allocated  = 1'b0;
        res.live_count    = fla_pkg::LIVE_W'(used_reg);

        case (state_reg)
            fla_pkg::S_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    req_next  = fla_pkg::req_e_t'(req_type);
                    addr_next = new_addr;
                    if (fla_pkg::req_e_t'(req_type) == fla_pkg::REQ_ALLOC) begin
                        known_next = head_reg < fill_reg;
                    end else begin
                        known_next = id_known;
                    end
                    state_next = fla_pkg::S_EXEC;
                end
            end
            fla_pkg::S_EXEC: begin
                if (res_room) begin
                    res_valid  = 1'b1;
                    state_next = fla_pkg::S_IDLE;
                    case (req_reg)
                        fla_pkg::REQ_ALLOC: begin
                            if (head_reg == LINK_W'(POOL_SIZE)) begin
                                res.status = fla_pkg::ST_EXHAUSTED;
                            end else begin
                                // pop the head
                                ram_wr_en         = 1'b1;
                                ram_wr_data       = {1'b1, link};
                                head_next         = link;
                                used_next         = used_reg + 1'b1;
                                fill_next         = known_reg ? fill_reg : fill_reg + 1'b1;
                                res.granted_ident = fla_pkg::IDENT_W'(addr_reg);
                            end
                        end
                        fla_pkg::REQ_FREE: begin
                            if (alloc_flag) begin
                                // push in front of the old head
                                ram_wr_en   = 1'b1;
                                ram_wr_data = {1'b0, head_reg};
                                head_next   = LINK_W'(addr_reg);
                                used_next   = used_reg - 1'b1;
                            end else begin
                                res.status = fla_pkg::ST_BAD_FREE;
                            end
                        end
                        fla_pkg::REQ_QUERY: begin
                            res.is_allocated = alloc_flag;
                        end
                        default: begin
                        end
                    endcase
                    res.live_count = fla_pkg::LIVE_W'(used_next);
                end
            end
            default: begin
                state_next = fla_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire
